[src/spq_pkg.sv]
// Package for the sorted priority queue: item structs, opcode and status codes,
// sequencer states and default sizing. No dependencies.
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned PRIO_W       = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LIST   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_LISTED    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EX,
    S_FIND_RD,
    S_FIND_EX,
    S_DEL_RD,
    S_DEL_EX,
    S_LIST_RD,
    S_LIST_EX,
    S_RESP
  } state_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [ID_W-1:0]     task_id;
    logic [PRIO_W-1:0]   priority_req;
  } in_t;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_priority;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

endpackage

[src/spq_ram.sv]
// Entry store of the sorted priority queue: one write port, one read port
// with registered read data. Depends on spq_pkg.
module spq_ram #(
  parameter int unsigned DEPTH  = spq_pkg::CAPACITY_DEF,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  spq_pkg::entry_t     wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output spq_pkg::entry_t     rdata_o
);
  import spq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/spq_ctrl.sv]
// Sequencer of the sorted priority queue: walks the entry store one entry at a time for insert,
// search, shift and list, with a priority compare for insert and an ID compare for search. Depends on spq_pkg.
module spq_ctrl #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  spq_pkg::in_t       in_data_i,
  output logic               in_stall_o,
  input  logic               out_free_i,
  output logic               emit_o,
  output spq_pkg::out_t      emit_data_o,
  output logic               we_o,
  output logic [IDX_W-1:0]   waddr_o,
  output spq_pkg::entry_t    wdata_o,
  output logic [IDX_W-1:0]   raddr_o,
  input  spq_pkg::entry_t    rdata_i
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [PRIO_W-1:0]  prio_q, prio_d;
  logic               pop_q, pop_d;
  out_t               resp_q, resp_d;
  logic [CNT_W-1:0]   idx_m1;
  logic [CNT_W-1:0]   idx_p1;
  logic               prio_ge;
  logic               id_hit;

  assign idx_m1  = idx_q - CNT_W'(1);
  assign idx_p1  = idx_q + CNT_W'(1);
  assign prio_ge = (rdata_i.prio >= prio_q);
  assign id_hit  = pop_q || (rdata_i.id == id_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    id_q   <= id_d;
    prio_q <= prio_d;
    pop_q  <= pop_d;
    resp_q <= resp_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    id_d        = id_q;
    prio_d      = prio_q;
    pop_d       = pop_q;
    resp_d      = resp_q;
    in_stall_o  = (state_q != S_IDLE);
    emit_o      = 1'b0;
    emit_data_o = resp_q;
    we_o        = 1'b0;
    waddr_o     = idx_q[IDX_W-1:0];
    wdata_o.id   = id_q;
    wdata_o.prio = prio_q;
    raddr_o     = idx_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          id_d                = in_data_i.task_id;
          prio_d              = in_data_i.priority_req;
          idx_d               = '0;
          pop_d               = 1'b0;
          resp_d.status       = ST_EMPTY;
          resp_d.out_id       = '0;
          resp_d.out_priority = '0;
          resp_d.last         = 1'b1;
          case (in_data_i.opcode)
            OP_INSERT: begin
              if (cnt_q == CAP_CNT) begin
                resp_d.status = ST_FULL;
                state_d       = S_RESP;
              end else begin
                idx_d   = cnt_q;
                state_d = S_INS_RD;
              end
            end
            OP_POP: begin
              pop_d   = 1'b1;
              state_d = (cnt_q == '0) ? S_RESP : S_FIND_RD;
            end
            OP_REMOVE: begin
              state_d = (cnt_q == '0) ? S_RESP : S_FIND_RD;
            end
            OP_LIST: begin
              state_d = (cnt_q == '0) ? S_RESP : S_LIST_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          we_o          = 1'b1;
          cnt_d         = cnt_q + CNT_W'(1);
          resp_d.status = ST_ADDED;
          state_d       = S_RESP;
        end else begin
          raddr_o = idx_m1[IDX_W-1:0];
          state_d = S_INS_EX;
        end
      end
      S_INS_EX: begin
        we_o = 1'b1;
        if (prio_ge) begin
          cnt_d         = cnt_q + CNT_W'(1);
          resp_d.status = ST_ADDED;
          state_d       = S_RESP;
        end else begin
          wdata_o = rdata_i;
          idx_d   = idx_m1;
          state_d = S_INS_RD;
        end
      end
      S_FIND_RD: begin
        if (idx_q == cnt_q) begin
          resp_d.status = ST_NOT_FOUND;
          state_d       = S_RESP;
        end else begin
          state_d = S_FIND_EX;
        end
      end
      S_FIND_EX: begin
        if (id_hit) begin
          resp_d.status       = ST_REMOVED;
          resp_d.out_id       = rdata_i.id;
          resp_d.out_priority = rdata_i.prio;
          state_d             = S_DEL_RD;
        end else begin
          idx_d   = idx_p1;
          state_d = S_FIND_RD;
        end
      end
      S_DEL_RD: begin
        if (idx_p1 == cnt_q) begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_RESP;
        end else begin
          raddr_o = idx_p1[IDX_W-1:0];
          state_d = S_DEL_EX;
        end
      end
      S_DEL_EX: begin
        we_o    = 1'b1;
        wdata_o = rdata_i;
        idx_d   = idx_p1;
        state_d = S_DEL_RD;
      end
      S_LIST_RD: begin
        state_d = S_LIST_EX;
      end
      S_LIST_EX: begin
        if (out_free_i) begin
          emit_o                   = 1'b1;
          emit_data_o.status       = ST_LISTED;
          emit_data_o.out_id       = rdata_i.id;
          emit_data_o.out_priority = rdata_i.prio;
          emit_data_o.last         = (idx_p1 == cnt_q);
          if (idx_p1 == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_p1;
            state_d = S_LIST_RD;
          end
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_CNT)
    else $error("entry count above capacity");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> out_free_i)
    else $error("result issued while output register busy");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we_o)
    else $error("store written while idle");

  a_cnt_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_INS_RD ||
      $past(state_q) == S_INS_EX || $past(state_q) == S_DEL_RD))
    else $error("entry count changed outside insert or delete");

endmodule

[src/sorted_priority_queue_remove_by_id_top.sv]
// Sorted priority queue top level: one request at a time. Each entry walked takes a read state
// and an execute state, since the entry store has registered read data. The result register
// frees the output side; in_stall_o is high while busy. Reset clears the entry count, sequencer
// state and output valid flag; store contents stay undefined until written.
// Depends on spq_pkg, spq_ram and spq_ctrl.
module sorted_priority_queue_remove_by_id_top #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spq_pkg::out_t  out_data_o
);
  import spq_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic              out_valid_q;
  out_t              out_data_q;
  logic              out_free;
  logic              emit;
  out_t              emit_data;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic [IDX_W-1:0]  raddr;
  entry_t            rdata;

  assign out_free = !out_valid_q || !out_stall_i;

  spq_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .emit_data_o (emit_data),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
